[sv/periodic_task_scheduler_unit_defines.svh]
// ----------------------------------------------------------------------------
// periodic_task_scheduler_unit_defines
// Assertion helper macros for the periodic task scheduler.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_UNIT_DEFINES_SVH
// Implication checked every cycle outside reset.
`define PTS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[sv/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the periodic task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam logic [0:0] OP_SCHED = 1'b0;
  localparam logic [0:0] OP_LOAD  = 1'b1;
  localparam logic [0:0] REG_SCHED_MODE = 1'b0;
  localparam logic [0:0] REG_TASK_COUNT = 1'b1;
  localparam logic [30:0] KEY_CEIL = 31'h7FFF_FFFF;
  localparam logic [31:0] DELAY_NONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [0:0]  op;
    logic [31:0] now_ms;
    logic        finished;
    logic [2:0]  task_index;
    logic [7:0]  task_ident;
    logic [30:0] period;
    logic [31:0] exec_time;
    logic [31:0] first_release;
    logic [30:0] first_deadline;
  } in_item_t;

  typedef struct packed {
    logic        switched;
    logic [7:0]  active_id;
    logic        active_valid;
    logic        idle;
    logic [31:0] delay;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHARGE, ST_RELEASE, ST_SELECT, ST_DECIDE, ST_DELAY, ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic start;
    logic charge;
    logic release_step;
    logic select_step;
    logic decide;
    logic delay_init;
    logic delay_step;
    logic out_load;
    logic idx_clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_last;
    logic scan_empty;
  } status_t;

endpackage

[sv/pts_datapath.sv]
// ----------------------------------------------------------------------------
// pts_datapath
// Task table, scan index and per-step arithmetic of the scheduler.
// ----------------------------------------------------------------------------
module pts_datapath #(
  parameter int MAX_TASKS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  pts_pkg::in_item_t item,
  input  logic              sched_mode,
  input  logic [3:0]        task_count,
  input  pts_pkg::cmd_t     cmd,
  output pts_pkg::status_t  status,
  output pts_pkg::out_item_t result
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  logic [30:0] entry_period   [MAX_TASKS];
  logic [31:0] entry_budget   [MAX_TASKS];
  logic [31:0] entry_remaining[MAX_TASKS];
  logic [31:0] entry_release  [MAX_TASKS];
  logic [30:0] entry_deadline [MAX_TASKS];
  logic [7:0]  entry_ident    [MAX_TASKS];

  logic [IW-1:0] current_slot;
  logic          current_present;
  logic [31:0]   last_call_time;
  logic [31:0]   now;
  logic          fin;
  logic [IW-1:0] idx;
  logic [IW-1:0] best;
  logic [30:0]   best_key;
  logic          found;
  logic [31:0]   delay;
  logic          switched;

  // effective count, saturated at MAX_TASKS
  logic [CW-1:0] n_eff;
  always_comb begin
    if ({28'd0, task_count} > 32'(MAX_TASKS)) n_eff = CW'(MAX_TASKS);
    else n_eff = CW'(task_count);
  end

  assign status.idx_last   = (CW'(idx) + CW'(1)) >= n_eff;
  assign status.scan_empty = (n_eff == '0);

  logic [30:0] key_i, key_cur;
  assign key_i   = sched_mode ? entry_deadline[idx] : entry_period[idx];
  assign key_cur = sched_mode ? entry_deadline[current_slot] : entry_period[current_slot];

  logic [31:0] elapsed;
  assign elapsed = now - last_call_time;
  logic [31:0] until_i;
  assign until_i = entry_release[idx] - now;

  logic load_ok;
  assign load_ok = 32'(item.task_index) < 32'(MAX_TASKS);

  logic take_over, same;
  assign take_over = fin || (found && (!current_present || best_key < key_cur));
  assign same = (found == current_present) && (!found || best == current_slot);

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      entry_ident[IW'(item.task_index)]     <= item.task_ident;
      entry_period[IW'(item.task_index)]    <= item.period;
      entry_budget[IW'(item.task_index)]    <= item.exec_time;
      entry_release[IW'(item.task_index)]   <= item.first_release;
      entry_deadline[IW'(item.task_index)]  <= item.first_deadline;
    end
    if (cmd.start) begin
      now <= item.now_ms;
      fin <= item.finished;
    end
    if (cmd.charge) begin
      last_call_time <= now;
      if (current_present) begin
        fin <= elapsed >= entry_remaining[current_slot];
      end
      best_key <= pts_pkg::KEY_CEIL;
      best     <= '0;
      found    <= 1'b0;
    end
    if (cmd.release_step && now >= entry_release[idx]) begin
      entry_release[idx] <= entry_release[idx] + {1'b0, entry_period[idx]};
      if (sched_mode) entry_deadline[idx] <= entry_deadline[idx] + entry_period[idx];
    end
    if (cmd.select_step && entry_remaining[idx] != '0 && key_i < best_key) begin
      best_key <= key_i;
      best     <= idx;
      found    <= 1'b1;
    end
    if (cmd.decide) begin
      switched <= 1'b0;
      if (take_over && !same) begin
        current_present <= found;
        if (found) current_slot <= best;
        switched <= found;
      end
    end
    if (cmd.delay_init) begin
      delay <= current_present ? entry_remaining[current_slot] : pts_pkg::DELAY_NONE;
    end
    if (cmd.delay_step && until_i < delay) delay <= until_i;
    if (cmd.idx_clear) idx <= '0;
    else if (cmd.release_step || cmd.select_step || cmd.delay_step) idx <= idx + IW'(1);
    if (cmd.out_load) begin
      result.switched     <= switched;
      result.active_id    <= current_present ? entry_ident[current_slot] : 8'd0;
      result.active_valid <= current_present;
      result.idle         <= !found;
      result.delay        <= delay;
    end
    if (rst) begin
      last_call_time  <= '0;
      current_present <= 1'b0;
      current_slot    <= '0;
      idx             <= '0;
    end
  end

  // remaining time has a reset value: flops with synchronous clear
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) entry_remaining[i] <= '0;
    end else begin
      if (cmd.load && load_ok) entry_remaining[IW'(item.task_index)] <= '0;
      if (cmd.charge && current_present) begin
        if (elapsed >= entry_remaining[current_slot]) entry_remaining[current_slot] <= '0;
        else entry_remaining[current_slot] <= entry_remaining[current_slot] - elapsed;
      end
      if (cmd.release_step && now >= entry_release[idx]) entry_remaining[idx] <= entry_budget[idx];
    end
  end

endmodule

[sv/pts_controller.sv]
// ----------------------------------------------------------------------------
// pts_controller
// Sequencer for load and schedule items; owns both handshakes.
// ----------------------------------------------------------------------------
`include "periodic_task_scheduler_unit_defines.svh"
module pts_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [0:0]        in_op,
  output logic              out_valid,
  input  logic              out_ready,
  input  pts_pkg::status_t  status,
  output pts_pkg::cmd_t     cmd
);

  pts_pkg::state_t state, state_next;
  logic out_valid_next;
  // marks the end of the delay scan
  logic cmd_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pts_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      pts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == pts_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = pts_pkg::ST_CHARGE;
          end
        end
      end
      pts_pkg::ST_CHARGE: begin
        cmd.charge    = 1'b1;
        cmd.idx_clear = 1'b1;
        state_next = status.scan_empty ? pts_pkg::ST_DECIDE : pts_pkg::ST_RELEASE;
      end
      pts_pkg::ST_RELEASE: begin
        if (status.idx_last) begin
          cmd.idx_clear = 1'b1;
          state_next    = pts_pkg::ST_SELECT;
        end
        cmd.release_step = 1'b1;
      end
      pts_pkg::ST_SELECT: begin
        if (status.idx_last) begin
          cmd.idx_clear = 1'b1;
          state_next    = pts_pkg::ST_DECIDE;
        end
        cmd.select_step = 1'b1;
      end
      pts_pkg::ST_DECIDE: begin
        cmd.decide    = 1'b1;
        cmd.idx_clear = 1'b1;
        state_next    = pts_pkg::ST_DELAY;
      end
      pts_pkg::ST_DELAY: begin
        // init cycle seeds from current task; scan steps follow in ST_OUT
        cmd.delay_init = 1'b1;
        cmd.idx_clear  = 1'b1;
        state_next     = pts_pkg::ST_OUT;
      end
      pts_pkg::ST_OUT: begin
        // scan delays, then hold the result until the slot frees
        if (!status.scan_empty && !cmd_done) begin
          cmd.delay_step = 1'b1;
        end
        if (status.scan_empty || cmd_done) begin
          if (!out_valid || out_ready) begin
            cmd.out_load   = 1'b1;
            out_valid_next = 1'b1;
            state_next     = pts_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = pts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || state != pts_pkg::ST_OUT) cmd_done <= 1'b0;
    else if (cmd.delay_step && status.idx_last) cmd_done <= 1'b1;
  end

  `PTS_ASSERT(a_ready_idle, in_ready, state == pts_pkg::ST_IDLE, "ready outside idle")
  `PTS_ASSERT(a_one_step, 1'b1, $onehot0({cmd.release_step, cmd.select_step, cmd.delay_step}),
    "overlapping scan steps")
  `PTS_ASSERT_NEXT(a_out_load, cmd.out_load, out_valid, "result not presented")
  `PTS_ASSERT_NEXT(a_sched_start, in_valid && in_ready && in_op == pts_pkg::OP_SCHED,
    state == pts_pkg::ST_CHARGE, "schedule item not started")

endmodule

[sv/periodic_task_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// periodic_task_scheduler_unit
// Rate monotonic / EDF scheduler over a table of periodic tasks.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready, in_data): a load item writes one table
//   entry and gives no result. A schedule item charges the running task,
//   releases due tasks, picks the best task and computes the delay, giving
//   one result on the out channel (out_valid/out_ready). One sequencer
//   walks the entries in use once each for release, selection and delay,
//   one entry per cycle.
//   The result sits in an output register; the next item is accepted while
//   it waits, but a new result waits for the register to free, so a stalled
//   receiver holds the block after its next schedule scan.
//   Configuration (cfg_we, cfg_index, cfg_data) must be written only while
//   idle; the block does not enforce it.
//   Reset: sync, active high; mode RM, task_count 1, no current task,
//   remaining times zero. Other table fields are undefined until loaded.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_unit #(
  parameter int MAX_TASKS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pts_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  logic       sched_mode;
  logic [3:0] task_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode <= 1'b0;
      task_count <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        pts_pkg::REG_SCHED_MODE: sched_mode <= cfg_data[0];
        pts_pkg::REG_TASK_COUNT: task_count <= cfg_data;
        default: ;
      endcase
    end
  end

  pts_pkg::cmd_t    cmd;
  pts_pkg::status_t status;

  pts_controller u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_data.op),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .cmd(cmd)
  );

  pts_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk(clk), .rst(rst), .item(in_data),
    .sched_mode(sched_mode), .task_count(task_count),
    .cmd(cmd), .status(status), .result(out_data)
  );

endmodule

[test/tb_periodic_task_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// tb_periodic_task_scheduler_unit
// Loads task tables and issues schedule calls under RM and EDF modes with
// several task counts. Every schedule result is checked field by field
// against an in-bench model of the scheduler, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_periodic_task_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  class sched_scoreboard;
    logic [30:0] per_tbl [8];
    logic [31:0] budget_tbl [8];
    logic [31:0] left_tbl [8];
    logic [31:0] rel_tbl [8];
    logic [30:0] dl_tbl [8];
    logic [7:0]  id_tbl [8];
    logic [2:0]  cur_slot;
    logic        cur_ok;
    logic [31:0] last_t;
    logic        mode;
    logic [3:0]  cnt;
    pts_pkg::out_item_t sched_q [$];
    int          errors;
    int          n_load;
    int          n_sched;
    int          n_switch;

    function new();
      foreach (left_tbl[i]) left_tbl[i] = '0;
      cur_slot = '0;
      cur_ok   = 1'b0;
      last_t   = '0;
      mode     = 1'b0;
      cnt      = 4'd1;
      errors   = 0;
      n_load   = 0;
      n_sched  = 0;
      n_switch = 0;
    endfunction

    function logic [30:0] key_of(int i);
      return mode ? dl_tbl[i] : per_tbl[i];
    endfunction

    function void note_item(pts_pkg::in_item_t it);
      int          n;
      int          best;
      logic [31:0] el, dly, till;
      logic [30:0] best_key;
      logic        fin, found, sw, same;
      pts_pkg::out_item_t r;
      if (it.op == pts_pkg::OP_LOAD) begin
        id_tbl[it.task_index]     = it.task_ident;
        per_tbl[it.task_index]    = it.period;
        budget_tbl[it.task_index] = it.exec_time;
        rel_tbl[it.task_index]    = it.first_release;
        dl_tbl[it.task_index]     = it.first_deadline;
        left_tbl[it.task_index]   = '0;
        n_load++;
        return;
      end
      n        = (cnt > 8) ? 8 : int'(cnt);
      el       = it.now_ms - last_t;
      last_t   = it.now_ms;
      fin      = it.finished;
      best     = 0;
      best_key = pts_pkg::KEY_CEIL;
      found    = 1'b0;
      sw       = 1'b0;
      if (cur_ok) begin
        if (el >= left_tbl[cur_slot]) begin
          left_tbl[cur_slot] = '0;
          fin = 1'b1;
        end else begin
          left_tbl[cur_slot] -= el;
          fin = 1'b0;
        end
      end
      for (int i = 0; i < n; i++) begin
        if (it.now_ms >= rel_tbl[i]) begin
          left_tbl[i] = budget_tbl[i];
          rel_tbl[i] += {1'b0, per_tbl[i]};
          if (mode) dl_tbl[i] += per_tbl[i];
        end
      end
      for (int i = 0; i < n; i++) begin
        if (left_tbl[i] != 0 && key_of(i) < best_key) begin
          best_key = key_of(i);
          best     = i;
          found    = 1'b1;
        end
      end
      if (fin || (found && (!cur_ok || best_key < key_of(cur_slot)))) begin
        same = (found == cur_ok) && (!found || best == cur_slot);
        if (!same) begin
          cur_ok = found;
          if (found) cur_slot = 3'(best);
          sw = found;
        end
      end
      dly = pts_pkg::DELAY_NONE;
      if (cur_ok && left_tbl[cur_slot] < dly) dly = left_tbl[cur_slot];
      for (int i = 0; i < n; i++) begin
        till = rel_tbl[i] - it.now_ms;
        if (till < dly) dly = till;
      end
      r.switched     = sw;
      r.active_id    = cur_ok ? id_tbl[cur_slot] : 8'd0;
      r.active_valid = cur_ok;
      r.idle         = !found;
      r.delay        = dly;
      sched_q.push_back(r);
      n_sched++;
      if (sw) n_switch++;
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
    endfunction

    function void check_result(pts_pkg::out_item_t got);
      pts_pkg::out_item_t e;
      if (sched_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result with nothing expected: %p", $realtime, got);
        return;
      end
      e = sched_q.pop_front();
      if (got.switched !== e.switched)
        report("switched", 32'(e.switched), 32'(got.switched));
      if (got.active_id !== e.active_id)
        report("active_id", 32'(e.active_id), 32'(got.active_id));
      if (got.active_valid !== e.active_valid)
        report("active_valid", 32'(e.active_valid), 32'(got.active_valid));
      if (got.idle !== e.idle) report("idle", 32'(e.idle), 32'(got.idle));
      if (got.delay !== e.delay) report("delay", e.delay, got.delay);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  pts_pkg::in_item_t  in_data;
  logic        out_valid;
  logic        out_ready;
  pts_pkg::out_item_t out_data;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [3:0]  cfg_data;

  sched_scoreboard sb = new();
  logic [31:0] t_now;
  int          hold_left;
  int          stall_left;
  bit          no_idle;

  periodic_task_scheduler_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) stall_left = rand_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function pts_pkg::in_item_t rand_fields();
    pts_pkg::in_item_t it;
    it.op             = 1'($urandom_range(0, 1));
    it.now_ms         = $urandom;
    it.finished       = 1'($urandom_range(0, 1));
    it.task_index     = 3'($urandom_range(0, 7));
    it.task_ident     = 8'($urandom_range(0, 255));
    it.period         = 31'($urandom);
    it.exec_time      = $urandom;
    it.first_release  = $urandom;
    it.first_deadline = 31'($urandom);
    return it;
  endfunction

  function pts_pkg::in_item_t mk_sched();
    pts_pkg::in_item_t it;
    int r;
    it    = rand_fields();
    it.op = pts_pkg::OP_SCHED;
    r     = $urandom_range(0, 99);
    if (r < 85) t_now += $urandom_range(0, 15);
    else if (r < 95) t_now += $urandom_range(16, 200);
    else t_now = $urandom;
    it.now_ms = t_now;
    return it;
  endfunction

  function pts_pkg::in_item_t mk_load(int idx);
    pts_pkg::in_item_t it;
    int r;
    it            = rand_fields();
    it.op         = pts_pkg::OP_LOAD;
    it.task_index = 3'(idx);
    r = $urandom_range(0, 99);
    if (r < 80) it.period = 31'($urandom_range(1, 60));
    else if (r < 90) it.period = pts_pkg::KEY_CEIL;
    else it.period = 31'($urandom_range(1, 32'h7FFF_FFFF));
    r = $urandom_range(0, 99);
    if (r < 80) it.exec_time = $urandom_range(1, 25);
    else if (r < 90) it.exec_time = '0;
    r = $urandom_range(0, 99);
    if (r < 85) it.first_release = t_now + $urandom_range(0, 40);
    r = $urandom_range(0, 99);
    if (r < 80) it.first_deadline = 31'(t_now + $urandom_range(1, 80));
    else if (r < 90) it.first_deadline = pts_pkg::KEY_CEIL;
    return it;
  endfunction

  task automatic send(pts_pkg::in_item_t it);
    int g;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    g = rand_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.sched_q.size() != 0) @(posedge clk);
  endtask

  // only while idle: drained and past the scan latency
  task automatic write_cfg(logic md, logic [3:0] tc);
    drain();
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= pts_pkg::REG_SCHED_MODE;
    cfg_data  <= {3'b000, md};
    @(posedge clk);
    sb.mode   = md;
    cfg_index <= pts_pkg::REG_TASK_COUNT;
    cfg_data  <= tc;
    @(posedge clk);
    sb.cnt    = tc;
    cfg_we    <= 1'b0;
  endtask

  task automatic sched_at(logic [31:0] t, logic fin);
    pts_pkg::in_item_t it;
    it          = mk_sched();
    t_now       = t;
    it.now_ms   = t;
    it.finished = fin;
    send(it);
  endtask

  logic [0:0] mode_list [8] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  logic [3:0] cnt_list  [8] = '{4'd8, 4'd8, 4'd3, 4'd15, 4'd0, 4'd5, 4'd1, 4'd12};

  initial begin
    pts_pkg::in_item_t it;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    t_now      = '0;
    hold_left  = 0;
    stall_left = 0;
    no_idle    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fill every entry first so no scan sees an unloaded one
    for (int i = 0; i < 8; i++) begin
      it = mk_load(i);
      if (i == 0) begin
        it.period = 31'd10; it.exec_time = 32'd3; it.first_release = 32'd0;
        it.first_deadline = 31'd12;
      end
      if (i == 1) begin
        it.period = pts_pkg::KEY_CEIL; it.exec_time = 32'hFFFF_FFFF; it.first_release = 32'd0;
        it.first_deadline = pts_pkg::KEY_CEIL;
      end
      if (i == 2) begin
        it.period = 31'd5; it.exec_time = 32'd0; it.first_release = 32'd0;
      end
      send(it);
    end
    sched_at(32'd0, 1'b1);
    sched_at(32'd0, 1'b0);
    sched_at(32'd2, 1'b0);
    sched_at(32'd7, 1'b1);
    write_cfg(1'b0, 4'd8);
    sched_at(32'd10, 1'b0);
    sched_at(32'd10, 1'b1);
    write_cfg(1'b1, 4'd8);
    sched_at(32'd25, 1'b0);
    sched_at(32'hFFFF_FFF0, 1'b0);
    sched_at(32'd5, 1'b1);
    it = mk_load(3);
    it.period = 31'd1; it.exec_time = 32'd1; it.first_release = 32'hFFFF_FFFF;
    it.first_deadline = pts_pkg::KEY_CEIL;
    send(it);
    sched_at(32'hFFFF_FFFF, 1'b0);
    sched_at(32'd6, 1'b0);

    // random phases over several settings
    for (int p = 0; p < 8; p++) begin
      write_cfg(mode_list[p], cnt_list[p]);
      no_idle = (p == 2);
      for (int k = 0; k < 54; k++) begin
        if (p == 3 && k == 20) hold_left = 300;
        if (p == 5 && k == 27) drain();
        if ($urandom_range(0, 99) < 22) send(mk_load($urandom_range(0, 7)));
        else send(mk_sched());
      end
    end
    no_idle = 1'b0;
    drain();
    repeat (40) @(posedge clk);

    $display("Covered %0d table loads and %0d schedule calls (%0d task switches),",
             sb.n_load, sb.n_sched, sb.n_switch);
    $display("both policies, task counts 0 to 15, %0d mismatches.", sb.errors);
    if (sb.errors == 0 && sb.sched_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout waiting for the scheduler");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/pts_pkg.sv
sv/pts_datapath.sv
sv/pts_controller.sv
sv/periodic_task_scheduler_unit.sv
test/tb_periodic_task_scheduler_unit.sv
